/* rtl/mwspi_pkg.sv */
package mwspi_pkg;

    // field and storage widths
    localparam int NUM_WHEELS = 4;
    localparam int WHEEL_W    = 2;
    localparam int DATA_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int INTEG_W    = 24;
    localparam int QUO_W      = 15;

    // shared multiplier: wide signed operand times short signed operand, 4 bits a step
    localparam int OPA_W     = 40;
    localparam int OPB_W     = 18;
    localparam int DIG_W     = 4;
    localparam int MAG_W     = 20;
    localparam int MUL_STEPS = MAG_W / DIG_W;
    localparam int STEP_W    = $clog2(MUL_STEPS + 1);
    localparam int PROD_W    = 56;

    // divider step counter
    localparam int DIV_STEP_W = $clog2(QUO_W);

    // parameter defaults
    localparam int ROTATE_LIMIT_DEF = 300;
    localparam int OUTPUT_LIMIT_DEF = 16384;

    // register reset values
    localparam logic [15:0] RST_PROP_GAIN = 16'd25600;
    localparam logic [15:0] RST_INT_GAIN  = 16'd0;
    localparam logic [14:0] RST_INT_LIMIT = 15'd12000;
    localparam logic [15:0] RST_BASE      = 16'd256;
    localparam logic [15:0] RST_RPM       = 16'd256;
    localparam logic [14:0] RST_MAX_RPM   = 15'd8000;

    // wheel order
    localparam logic [WHEEL_W-1:0] WHL_FR = 2'd0;
    localparam logic [WHEEL_W-1:0] WHL_FL = 2'd1;
    localparam logic [WHEEL_W-1:0] WHL_BL = 2'd2;
    localparam logic [WHEEL_W-1:0] WHL_BR = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INT_GAIN    = 3'd1,
        REG_INT_LIMIT   = 3'd2,
        REG_ROT_BASE    = 3'd3,
        REG_ROT_XOFF    = 3'd4,
        REG_ROT_YOFF    = 3'd5,
        REG_RPM_RATIO   = 3'd6,
        REG_MAX_RPM     = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_LEV, S_LEV_W, S_RPM, S_RPM_W, S_CHK,
        S_SCL, S_SCL_W, S_DIV, S_DIV_W,
        S_ERR, S_KI, S_KI_W, S_KP, S_KP_W, S_DONE
    } t_state;

    typedef struct packed {
        logic                    start;
        logic signed [OPA_W-1:0] a;
        logic signed [OPB_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] num;
        logic [OPA_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

/* rtl/mwspi_in_if.sv */
interface mwspi_in_if import mwspi_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] drive_speed;
    logic signed [DATA_W-1:0] strafe_speed;
    logic signed [DATA_W-1:0] rotate_speed;
    logic signed [DATA_W-1:0] speed_front_right;
    logic signed [DATA_W-1:0] speed_front_left;
    logic signed [DATA_W-1:0] speed_back_left;
    logic signed [DATA_W-1:0] speed_back_right;

    modport source (
        output valid, drive_speed, strafe_speed, rotate_speed,
               speed_front_right, speed_front_left, speed_back_left, speed_back_right,
        input  ready
    );
    modport sink (
        input  valid, drive_speed, strafe_speed, rotate_speed,
               speed_front_right, speed_front_left, speed_back_left, speed_back_right,
        output ready
    );
endinterface

/* rtl/mwspi_out_if.sv */
interface mwspi_out_if import mwspi_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] drive_front_right;
    logic signed [DATA_W-1:0] drive_front_left;
    logic signed [DATA_W-1:0] drive_back_left;
    logic signed [DATA_W-1:0] drive_back_right;
    logic                     targets_scaled;

    modport source (
        output valid, drive_front_right, drive_front_left, drive_back_left,
               drive_back_right, targets_scaled,
        input  ready
    );
    modport sink (
        input  valid, drive_front_right, drive_front_left, drive_back_left,
               drive_back_right, targets_scaled,
        output ready
    );
endinterface

/* rtl/mwspi_mul.sv */
module mwspi_mul import mwspi_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mul_req                 i_req,
    output t_unit_stat               o_stat,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [OPA_W-1:0]       r_a;
    logic [MAG_W-1:0]              r_m;
    logic signed [PROD_W-1:0]      r_acc;
    logic [STEP_W-1:0]             r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic                          w_bneg;
    logic [OPB_W-1:0]              w_bmag;
    logic [DIG_W-1:0]              w_dig;
    logic signed [OPA_W+DIG_W:0]   w_pp;
    logic signed [PROD_W-1:0]      n_acc;

    // sign moves onto the wide operand, magnitude is consumed msb digit first
    assign w_bneg = i_req.b[OPB_W-1];
    assign w_bmag = w_bneg ? OPB_W'(-i_req.b) : OPB_W'(i_req.b);
    assign w_dig  = r_m[MAG_W-1 -: DIG_W];
    assign w_pp   = r_a * $signed({1'b0, w_dig});
    assign n_acc  = (r_acc <<< DIG_W) + PROD_W'(w_pp);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(MUL_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= w_bneg ? -i_req.a : i_req.a;
            r_m   <= {{(MAG_W-OPB_W){1'b0}}, w_bmag};
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_m   <= r_m << DIG_W;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod      = r_acc;

endmodule

/* rtl/mwspi_div.sv */
module mwspi_div import mwspi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output t_unit_stat       o_stat,
    output logic [QUO_W-1:0] o_quo
);

    logic [PROD_W-1:0]     r_num;
    logic [OPA_W-1:0]      r_den;
    logic [QUO_W-1:0]      r_q;
    logic [DIV_STEP_W-1:0] r_k;
    logic                  r_busy;
    logic                  r_done;

    logic [PROD_W-1:0]     w_sh;
    logic                  w_ge;

    // restoring division, quotient known to fit, one bit a cycle msb first
    assign w_sh = PROD_W'(r_den) << r_k;
    assign w_ge = r_num >= w_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_k    <= DIV_STEP_W'(QUO_W - 1);
            end else if (r_busy) begin
                r_k <= r_k - 1'b1;
                if (r_k == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_q   <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_num <= r_num - w_sh;
            end
            r_q <= {r_q[QUO_W-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_q;

endmodule

/* rtl/mecanum_wheel_speed_pi_control_top.sv */
// channel   dir  handshake      word
// i_in      in   valid/ready    chassis set points and four measured wheel speeds
// o_out     out  valid/ready    four saturated motor commands and scaled flag
// i_cfg_*   in   write enable   register index and 16 bit data, no read-back
//
// one word is worked at a time by a small sequencer around one shared 4-bit-digit
// multiplier and a 15-step restoring divider
// the result waits in an output register, the next word is taken meanwhile
// a full output register holds the sequencer in its last state, input stays not ready
// synchronous active-low reset clears configuration registers, integrators and the output valid flag
module mecanum_wheel_speed_pi_control_top import mwspi_pkg::*; #(
    parameter int ROTATE_LIMIT = ROTATE_LIMIT_DEF,
    parameter int OUTPUT_LIMIT = OUTPUT_LIMIT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mwspi_in_if.sink             i_in,
    mwspi_out_if.source          o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]          i_cfg_data
);

    localparam logic signed [DATA_W:0]   ROT_LIM   = (DATA_W+1)'(ROTATE_LIMIT);
    localparam logic signed [PROD_W-1:0] OUT_LIM   = PROD_W'(OUTPUT_LIMIT);
    localparam logic signed [DATA_W-1:0] OUT_LIM16 = DATA_W'(OUTPUT_LIMIT);

    // configuration registers
    logic [15:0]        r_kp, r_ki, r_base, r_rpm;
    logic [14:0]        r_ilim, r_lim;
    logic signed [15:0] r_xoff, r_yoff;

    // captured word
    logic signed [DATA_W-1:0] r_d, r_s, r_r;
    logic signed [DATA_W-1:0] r_meas [NUM_WHEELS];

    // working state
    t_state                  r_state, n_state;
    logic [WHEEL_W-1:0]      r_wheel;
    logic signed [OPA_W-1:0] r_v;
    logic signed [OPA_W-1:0] r_tgt [NUM_WHEELS];
    logic [OPA_W-1:0]        r_peak;
    logic                    r_scaled;
    logic [PROD_W-1:0]       r_num;
    logic                    r_tneg;
    logic signed [OPA_W-1:0] r_err;
    logic signed [INTEG_W-1:0] r_integ [NUM_WHEELS];
    logic signed [DATA_W-1:0]  r_drv [NUM_WHEELS];

    // output register
    logic                     r_oval;
    logic signed [DATA_W-1:0] r_odrv [NUM_WHEELS];
    logic                     r_oscl;

    // shared units
    t_mul_req                 w_mreq;
    t_unit_stat               w_mstat;
    logic signed [PROD_W-1:0] w_prod;
    t_div_req                 w_dreq;
    t_unit_stat               w_dstat;
    logic [QUO_W-1:0]         w_quo;

    mwspi_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_stat  (w_mstat),
        .o_prod  (w_prod)
    );

    mwspi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_stat  (w_dstat),
        .o_quo   (w_quo)
    );

    logic w_accept, w_last, w_over, w_load;
    assign w_accept = i_in.valid && i_in.ready;
    assign w_last   = r_wheel == WHEEL_W'(NUM_WHEELS - 1);
    assign w_over   = r_peak > {{(OPA_W-15){1'b0}}, r_lim};
    assign w_load   = !r_oval || o_out.ready;

    // rotation clamp on capture
    logic signed [DATA_W:0]   w_rot_x;
    logic signed [DATA_W-1:0] w_rot;
    always_comb begin
        w_rot_x = {i_in.rotate_speed[DATA_W-1], i_in.rotate_speed};
        if (w_rot_x > ROT_LIM) begin
            w_rot = DATA_W'(ROT_LIM);
        end else if (w_rot_x < -ROT_LIM) begin
            w_rot = DATA_W'(-ROT_LIM);
        end else begin
            w_rot = i_in.rotate_speed;
        end
    end

    // lever ratio and linear term of the current wheel
    logic signed [OPB_W-1:0] w_b18, w_x18, w_y18, w_lever;
    logic signed [OPB_W-1:0] w_d18, w_s18, w_lin;
    logic signed [OPA_W-1:0] w_lin_q;
    always_comb begin
        w_b18 = $signed({2'b00, r_base});
        w_x18 = OPB_W'(r_xoff);
        w_y18 = OPB_W'(r_yoff);
        w_d18 = OPB_W'(r_d);
        w_s18 = OPB_W'(r_s);
        case (r_wheel)
            WHL_FR: begin
                w_lever = w_b18 - w_x18 + w_y18;
                w_lin   = w_s18 - w_d18;
            end
            WHL_FL: begin
                w_lever = w_b18 - w_x18 - w_y18;
                w_lin   = w_s18 + w_d18;
            end
            WHL_BL: begin
                w_lever = w_b18 + w_x18 - w_y18;
                w_lin   = w_d18 - w_s18;
            end
            default: begin
                w_lever = w_b18 + w_x18 + w_y18;
                w_lin   = -w_s18 - w_d18;
            end
        endcase
    end
    assign w_lin_q = OPA_W'(w_lin) <<< 8;

    // target: product over 65536, toward zero
    logic signed [PROD_W-1:0] w_t_rnd, w_t_sh;
    logic signed [OPA_W-1:0]  w_tgt;
    logic [OPA_W-1:0]         w_tabs;
    assign w_t_rnd = w_prod + $signed({{(PROD_W-16){1'b0}}, {16{w_prod[PROD_W-1]}}});
    assign w_t_sh  = w_t_rnd >>> 16;
    assign w_tgt   = $signed(w_t_sh[OPA_W-1:0]);
    assign w_tabs  = w_tgt[OPA_W-1] ? OPA_W'(-w_tgt) : OPA_W'(w_tgt);

    // magnitude of the scaling product and the signed quotient
    logic [PROD_W-1:0]       w_pabs;
    logic signed [OPA_W-1:0] w_qs;
    assign w_pabs = w_prod[PROD_W-1] ? PROD_W'(-w_prod) : PROD_W'(w_prod);
    assign w_qs   = r_tneg ? -$signed({{(OPA_W-QUO_W){1'b0}}, w_quo})
                           :  $signed({{(OPA_W-QUO_W){1'b0}}, w_quo});

    // integrator update and clamp
    logic signed [PROD_W-1:0] w_ilim, w_iacc, w_icl;
    assign w_ilim = $signed({{(PROD_W-23){1'b0}}, r_ilim, 8'b0});
    assign w_iacc = PROD_W'(r_integ[r_wheel]) + w_prod;
    always_comb begin
        if (w_iacc > w_ilim) begin
            w_icl = w_ilim;
        end else if (w_iacc < -w_ilim) begin
            w_icl = -w_ilim;
        end else begin
            w_icl = w_iacc;
        end
    end

    // motor command: sum over 256 toward zero, then saturate
    logic signed [PROD_W-1:0] w_o_sum, w_o_rnd, w_o_q, w_o_cl;
    assign w_o_sum = w_prod + PROD_W'(r_integ[r_wheel]);
    assign w_o_rnd = w_o_sum + $signed({{(PROD_W-8){1'b0}}, {8{w_o_sum[PROD_W-1]}}});
    assign w_o_q   = w_o_rnd >>> 8;
    always_comb begin
        if (w_o_q > OUT_LIM) begin
            w_o_cl = OUT_LIM;
        end else if (w_o_q < -OUT_LIM) begin
            w_o_cl = -OUT_LIM;
        end else begin
            w_o_cl = w_o_q;
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in.valid) n_state = S_LEV;
            S_LEV:   n_state = S_LEV_W;
            S_LEV_W: if (w_mstat.done) n_state = S_RPM;
            S_RPM:   n_state = S_RPM_W;
            S_RPM_W: if (w_mstat.done) n_state = w_last ? S_CHK : S_LEV;
            S_CHK:   n_state = w_over ? S_SCL : S_ERR;
            S_SCL:   n_state = S_SCL_W;
            S_SCL_W: if (w_mstat.done) n_state = S_DIV;
            S_DIV:   n_state = S_DIV_W;
            S_DIV_W: if (w_dstat.done) n_state = w_last ? S_ERR : S_SCL;
            S_ERR:   n_state = S_KI;
            S_KI:    n_state = S_KI_W;
            S_KI_W:  if (w_mstat.done) n_state = S_KP;
            S_KP:    n_state = S_KP_W;
            S_KP_W:  if (w_mstat.done) n_state = w_last ? S_DONE : S_ERR;
            S_DONE:  if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: unit requests and input ready
    always_comb begin
        w_mreq       = '0;
        w_dreq.start = 1'b0;
        w_dreq.num   = r_num;
        w_dreq.den   = r_peak;
        case (r_state)
            S_LEV: begin
                w_mreq.start = 1'b1;
                w_mreq.a     = OPA_W'(r_r);
                w_mreq.b     = w_lever;
            end
            S_RPM: begin
                w_mreq.start = 1'b1;
                w_mreq.a     = r_v;
                w_mreq.b     = $signed({2'b00, r_rpm});
            end
            S_SCL: begin
                w_mreq.start = 1'b1;
                w_mreq.a     = r_tgt[r_wheel];
                w_mreq.b     = $signed({3'b000, r_lim});
            end
            S_DIV: begin
                w_dreq.start = 1'b1;
            end
            S_KI: begin
                w_mreq.start = 1'b1;
                w_mreq.a     = r_err;
                w_mreq.b     = $signed({2'b00, r_ki});
            end
            S_KP: begin
                w_mreq.start = 1'b1;
                w_mreq.a     = r_err;
                w_mreq.b     = $signed({2'b00, r_kp});
            end
            default: begin
                w_mreq = '0;
            end
        endcase
    end
    assign i_in.ready = r_state == S_IDLE;

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wheel <= '0;
            r_oval  <= 1'b0;
            for (int i = 0; i < NUM_WHEELS; i++) begin
                r_integ[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if ((r_state == S_RPM_W && w_mstat.done) || (r_state == S_DIV_W && w_dstat.done)
                || (r_state == S_KP_W && w_mstat.done)) begin
                r_wheel <= r_wheel + 1'b1;
            end
            if (r_state == S_KI_W && w_mstat.done) begin
                r_integ[r_wheel] <= w_icl[INTEG_W-1:0];
            end
            if (r_state == S_DONE && w_load) begin
                r_oval <= 1'b1;
            end else if (o_out.ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= RST_PROP_GAIN;
            r_ki   <= RST_INT_GAIN;
            r_ilim <= RST_INT_LIMIT;
            r_base <= RST_BASE;
            r_xoff <= '0;
            r_yoff <= '0;
            r_rpm  <= RST_RPM;
            r_lim  <= RST_MAX_RPM;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_PROP_GAIN: r_kp   <= i_cfg_data;
                REG_INT_GAIN:  r_ki   <= i_cfg_data;
                REG_INT_LIMIT: r_ilim <= i_cfg_data[14:0];
                REG_ROT_BASE:  r_base <= i_cfg_data;
                REG_ROT_XOFF:  r_xoff <= $signed(i_cfg_data);
                REG_ROT_YOFF:  r_yoff <= $signed(i_cfg_data);
                REG_RPM_RATIO: r_rpm  <= i_cfg_data;
                REG_MAX_RPM:   r_lim  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_d       <= i_in.drive_speed;
            r_s       <= i_in.strafe_speed;
            r_r       <= w_rot;
            r_meas[0] <= i_in.speed_front_right;
            r_meas[1] <= i_in.speed_front_left;
            r_meas[2] <= i_in.speed_back_left;
            r_meas[3] <= i_in.speed_back_right;
            r_peak    <= '0;
            r_scaled  <= 1'b0;
        end
        if (r_state == S_LEV_W && w_mstat.done) begin
            r_v <= w_lin_q + $signed(w_prod[OPA_W-1:0]);
        end
        if (r_state == S_RPM_W && w_mstat.done) begin
            r_tgt[r_wheel] <= w_tgt;
            if (w_tabs > r_peak) begin
                r_peak <= w_tabs;
            end
        end
        if (r_state == S_CHK) begin
            r_scaled <= w_over;
        end
        if (r_state == S_SCL_W && w_mstat.done) begin
            r_num  <= w_pabs;
            r_tneg <= r_tgt[r_wheel][OPA_W-1];
        end
        if (r_state == S_DIV_W && w_dstat.done) begin
            r_tgt[r_wheel] <= w_qs;
        end
        if (r_state == S_ERR) begin
            r_err <= r_tgt[r_wheel] - OPA_W'(r_meas[r_wheel]);
        end
        if (r_state == S_KP_W && w_mstat.done) begin
            r_drv[r_wheel] <= w_o_cl[DATA_W-1:0];
        end
        if (r_state == S_DONE && w_load) begin
            for (int i = 0; i < NUM_WHEELS; i++) begin
                r_odrv[i] <= r_drv[i];
            end
            r_oscl <= r_scaled;
        end
    end

    // result port
    assign o_out.valid             = r_oval;
    assign o_out.drive_front_right = r_odrv[0];
    assign o_out.drive_front_left  = r_odrv[1];
    assign o_out.drive_back_left   = r_odrv[2];
    assign o_out.drive_back_right  = r_odrv[3];
    assign o_out.targets_scaled    = r_oscl;

`ifndef SYNTHESIS
    // a product only completes while the sequencer waits for it
    a_mul_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mstat.done |-> (r_state == S_LEV_W || r_state == S_RPM_W || r_state == S_SCL_W
                          || r_state == S_KI_W || r_state == S_KP_W))
        else $error("multiplier result arrived outside a wait state");

    // an accepted word starts the mixing pass on the first wheel
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_LEV && r_wheel == WHL_FR))
        else $error("accepted word did not start the sequence");

    // front-right and back-right commands stay within the saturation limit
    a_out_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.drive_front_right <= OUT_LIM16
                         && o_out.drive_front_right >= -OUT_LIM16
                         && o_out.drive_back_right <= OUT_LIM16
                         && o_out.drive_back_right >= -OUT_LIM16))
        else $error("motor command beyond saturation limit");
`endif

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb import mwspi_pkg::*; ;

    localparam int ROT_LIM      = ROTATE_LIMIT_DEF;
    localparam int OUT_LIM      = OUTPUT_LIMIT_DEF;
    localparam int SETTLE_CYC   = 300;
    localparam int RX_HOLD_CYC  = 1500;
    localparam int QUIET_LIMIT  = 6000;
    localparam int RAND_PHASES  = 11;
    localparam int PHASE_WORDS  = 100;

    // one control tick: set points plus measured wheel speeds, wheel order FR FL BL BR
    typedef struct {
        logic signed [15:0] drive;
        logic signed [15:0] strafe;
        logic signed [15:0] rotate;
        logic signed [15:0] meas [NUM_WHEELS];
    } tick_t;

    typedef struct {
        logic signed [15:0] cmd [NUM_WHEELS];
        logic               scaled;
    } motor_cmd_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [15:0] i_cfg_data;

    mwspi_in_if  in_if ();
    mwspi_out_if out_if ();

    mecanum_wheel_speed_pi_control_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor copy of registers and integrators
    logic [15:0] kp, ki, base_ratio, rpm_ratio;
    logic [14:0] integ_lim, max_rpm;
    logic signed [15:0] x_off, y_off;
    longint integ [NUM_WHEELS];

    tick_t      tick_q [$];
    motor_cmd_t cmd_q  [$];
    int         errors = 0;
    bit         tx_gaps, rx_gaps;
    int         hold_req = 0;

    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // mecanum mix, proportional scaling, PI step per wheel
    function automatic motor_cmd_t pi_tick(tick_t t);
        motor_cmd_t r;
        longint d, s, rot, b, x, y, peak, lim, ilim, v, e, acc, o;
        longint lever [NUM_WHEELS];
        longint lin [NUM_WHEELS];
        longint tgt [NUM_WHEELS];
        d = t.drive;
        s = t.strafe;
        rot = clamp_sym(longint'(t.rotate), ROT_LIM);
        b = longint'(base_ratio);
        x = x_off;
        y = y_off;
        lim = longint'(max_rpm);
        ilim = longint'(integ_lim) * 256;
        lever[0] = b - x + y;
        lever[1] = b - x - y;
        lever[2] = b + x - y;
        lever[3] = b + x + y;
        lin[0] = (s - d) * 256;
        lin[1] = (s + d) * 256;
        lin[2] = (d - s) * 256;
        lin[3] = (-s - d) * 256;
        peak = 0;
        for (int i = 0; i < NUM_WHEELS; i++) begin
            v = lin[i] + rot * lever[i];
            tgt[i] = (v * longint'(rpm_ratio)) / 65536;
            if (tgt[i] > peak) peak = tgt[i];
            if (-tgt[i] > peak) peak = -tgt[i];
        end
        r.scaled = peak > lim;
        if (r.scaled) begin
            for (int i = 0; i < NUM_WHEELS; i++) tgt[i] = (tgt[i] * lim) / peak;
        end
        for (int i = 0; i < NUM_WHEELS; i++) begin
            e = tgt[i] - longint'(t.meas[i]);
            acc = clamp_sym(integ[i] + e * longint'(ki), ilim);
            integ[i] = acc;
            o = clamp_sym((e * longint'(kp) + acc) / 256, OUT_LIM);
            r.cmd[i] = o[15:0];
        end
        return r;
    endfunction

    // driver: feeds queued ticks with optional gaps
    int tx_gap;
    always @(posedge i_clk) begin
        tick_t t;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            tx_gap <= 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                t.drive = in_if.drive_speed;
                t.strafe = in_if.strafe_speed;
                t.rotate = in_if.rotate_speed;
                t.meas[0] = in_if.speed_front_right;
                t.meas[1] = in_if.speed_front_left;
                t.meas[2] = in_if.speed_back_left;
                t.meas[3] = in_if.speed_back_right;
                cmd_q.push_back(pi_tick(t));
            end
            if (in_if.valid && !in_if.ready) begin
                // hold the word
            end else if (tx_gap != 0) begin
                tx_gap <= tx_gap - 1;
                in_if.valid <= 1'b0;
            end else if (tick_q.size() != 0) begin
                t = tick_q.pop_front();
                in_if.drive_speed <= t.drive;
                in_if.strafe_speed <= t.strafe;
                in_if.rotate_speed <= t.rotate;
                in_if.speed_front_right <= t.meas[0];
                in_if.speed_front_left <= t.meas[1];
                in_if.speed_back_left <= t.meas[2];
                in_if.speed_back_right <= t.meas[3];
                in_if.valid <= 1'b1;
                tx_gap <= tx_gaps ? $urandom_range(0, 17) : 0;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // monitor: random stalls, long hold on request, compare against oldest expectation
    int rx_stall, hold_cnt, hold_seen;
    always @(posedge i_clk) begin
        motor_cmd_t c;
        logic signed [15:0] got [NUM_WHEELS];
        int w;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_stall <= 0;
            hold_cnt <= 0;
            hold_seen <= 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got[0] = out_if.drive_front_right;
                got[1] = out_if.drive_front_left;
                got[2] = out_if.drive_back_left;
                got[3] = out_if.drive_back_right;
                if (cmd_q.size() == 0) begin
                    $display("%0t: unexpected word, no command pending", $time);
                    errors++;
                end else begin
                    c = cmd_q.pop_front();
                    for (int i = 0; i < NUM_WHEELS; i++) begin
                        if (got[i] !== c.cmd[i]) begin
                            $display("%0t: wheel %0d cmd expected %0d got %0d",
                                     $time, i, c.cmd[i], got[i]);
                            errors++;
                        end
                    end
                    if (out_if.targets_scaled !== c.scaled) begin
                        $display("%0t: targets_scaled expected %0b got %0b",
                                 $time, c.scaled, out_if.targets_scaled);
                        errors++;
                    end
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen <= hold_req;
                hold_cnt <= RX_HOLD_CYC;
                out_if.ready <= 1'b0;
            end else if (hold_cnt != 0) begin
                hold_cnt <= hold_cnt - 1;
                out_if.ready <= (hold_cnt == 1);
            end else if (out_if.valid && out_if.ready) begin
                w = rx_gaps ? $urandom_range(0, 17) : 0;
                rx_stall <= w;
                out_if.ready <= (w == 0);
            end else if (rx_stall != 0) begin
                rx_stall <= rx_stall - 1;
                out_if.ready <= (rx_stall == 1);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any handshake
    int quiet = 0;
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !i_rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > QUIET_LIMIT) begin
            $display("** mecanum_wheel_speed_pi_control_top: FAILED **");
            $finish;
        end
    end

    task automatic set_reg(t_cfg_idx idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_PROP_GAIN: kp = val;
            REG_INT_GAIN:  ki = val;
            REG_INT_LIMIT: integ_lim = val[14:0];
            REG_ROT_BASE:  base_ratio = val;
            REG_ROT_XOFF:  x_off = val;
            REG_ROT_YOFF:  y_off = val;
            REG_RPM_RATIO: rpm_ratio = val;
            REG_MAX_RPM:   max_rpm = val[14:0];
            default: ;
        endcase
    endtask

    task automatic set_all(logic [15:0] p, logic [15:0] i, logic [15:0] il, logic [15:0] b,
                           logic [15:0] x, logic [15:0] y, logic [15:0] r, logic [15:0] m);
        set_reg(REG_PROP_GAIN, p);
        set_reg(REG_INT_GAIN, i);
        set_reg(REG_INT_LIMIT, il);
        set_reg(REG_ROT_BASE, b);
        set_reg(REG_ROT_XOFF, x);
        set_reg(REG_ROT_YOFF, y);
        set_reg(REG_RPM_RATIO, r);
        set_reg(REG_MAX_RPM, m);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (tick_q.size() != 0 || in_if.valid || cmd_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic push_tick(int d, int s, int r, int fr, int fl, int bl, int br);
        tick_t t;
        t.drive = 16'(d);
        t.strafe = 16'(s);
        t.rotate = 16'(r);
        t.meas[0] = 16'(fr);
        t.meas[1] = 16'(fl);
        t.meas[2] = 16'(bl);
        t.meas[3] = 16'(br);
        tick_q.push_back(t);
    endtask

    // mostly realistic magnitudes, some full-range words
    function automatic int pick16();
        case ($urandom_range(0, 3))
            0:       return $signed(16'($urandom));
            1:       return $urandom_range(0, 600) - 300;
            default: return $urandom_range(0, 8000) - 4000;
        endcase
    endfunction

    function automatic logic [15:0] pick_reg(int lo, int hi);
        case ($urandom_range(0, 5))
            0:       return 16'(lo);
            1:       return 16'(hi);
            default: return 16'($urandom_range(0, hi - lo) + lo);
        endcase
    endfunction

    initial begin
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.drive_speed = '0;
        in_if.strafe_speed = '0;
        in_if.rotate_speed = '0;
        in_if.speed_front_right = '0;
        in_if.speed_front_left = '0;
        in_if.speed_back_left = '0;
        in_if.speed_back_right = '0;
        out_if.ready = 1'b0;
        kp = RST_PROP_GAIN;
        ki = RST_INT_GAIN;
        integ_lim = RST_INT_LIMIT;
        base_ratio = RST_BASE;
        x_off = '0;
        y_off = '0;
        rpm_ratio = RST_RPM;
        max_rpm = RST_MAX_RPM;
        for (int i = 0; i < NUM_WHEELS; i++) integ[i] = 0;
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero, field extremes, rotation clamp both sides
        push_tick(0, 0, 0, 0, 0, 0, 0);
        push_tick(32767, 32767, 32767, 32767, 32767, 32767, 32767);
        push_tick(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
        push_tick(100, -50, 301, 10, -10, 20, -20);
        push_tick(-100, 50, -301, -1, 1, -1, 1);
        push_tick(3000, 2000, 0, 0, 0, 0, 0);
        push_tick(-1, 1, -1, -32768, 32767, -32768, 32767);
        wait_drained();

        // integrator gain active, small limit
        set_all(256, 64, 100, 300, -50, 70, 600, 8000);
        repeat (4) push_tick(200, -100, 150, 0, 0, 0, 0);
        push_tick(-200, 100, -150, 5000, -5000, 5000, -5000);
        wait_drained();

        // register maxima, zero max rpm scales everything to zero
        set_all(65535, 65535, 32767, 65535, 16'h8000, 16'h7fff, 65535, 0);
        push_tick(32767, -32768, 32767, 1, -1, 1, -1);
        push_tick(0, 0, 0, 0, 0, 0, 0);
        push_tick(1, 0, 0, 32767, -32768, 0, 0);
        push_tick(-32768, 32767, -32768, 0, 0, 0, 0);
        wait_drained();

        // register minima, limit above nominal range
        set_all(0, 0, 0, 0, 16'h7fff, 16'h8000, 0, 32767);
        push_tick(32767, 32767, 300, 100, -100, 100, -100);
        push_tick(-32768, 0, -300, 0, 0, 0, 0);
        wait_drained();
        set_all(512, 300, 20000, 256, 0, 0, 256, 16384);
        push_tick(20000, 10000, 300, -3000, 0, 3000, 0);
        push_tick(-20000, -10000, -300, 0, 0, 0, 0);
        wait_drained();

        // random phases with random settings
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            set_all(pick_reg(0, 65535), pick_reg(0, 65535), pick_reg(0, 32767),
                    pick_reg(0, 65535), pick_reg(-32768, 32767), pick_reg(-32768, 32767),
                    pick_reg(0, 65535), pick_reg(0, 32767));
            tx_gaps = (ph % 3) != 0;
            rx_gaps = (ph % 4) != 1;
            for (int n = 0; n < PHASE_WORDS; n++)
                push_tick(pick16(), pick16(), pick16(), pick16(), pick16(), pick16(), pick16());
            if (ph == 2) begin
                // receiver holds off while sender keeps offering words
                tx_gaps = 1'b0;
                repeat (5) @(posedge i_clk);
                hold_req = hold_req + 1;
            end
            wait_drained();
        end

        if (errors == 0)
            $display("** mecanum_wheel_speed_pi_control_top: PASSED **");
        else
            $display("** mecanum_wheel_speed_pi_control_top: FAILED **");
        $finish;
    end

endmodule

/* files.f */
rtl/mwspi_pkg.sv
rtl/mwspi_in_if.sv
rtl/mwspi_out_if.sv
rtl/mwspi_mul.sv
rtl/mwspi_div.sv
rtl/mecanum_wheel_speed_pi_control_top.sv
test/tb.sv
